// File: rtl/brrt_pkg.sv
// ----------------------------------------------------------------------------
// Bus request/response tracker package
// Shared constants, opcodes, state type and controller/datapath command types.
// ----------------------------------------------------------------------------
package brrt_pkg;

  localparam int unsigned TableEntriesDefault = 16;
  localparam logic [15:0] QueryGapReset = 16'd1600;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_TRANSMIT = 3'd1;
  localparam logic [2:0] OP_RESPONSE = 3'd2;
  localparam logic [2:0] OP_CHECK    = 3'd3;
  localparam logic [2:0] OP_EXPIRE   = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;
  localparam logic [2:0] OP_CLEAR    = 3'd6;

  localparam logic [1:0] PH_PENDING = 2'd0;
  localparam logic [1:0] PH_DONE    = 2'd1;
  localparam logic [1:0] PH_EXPIRED = 2'd2;

  localparam logic [0:0] CFG_EXPIRE = 1'b0;
  localparam logic [0:0] CFG_GAP    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_SKIP,
    ST_FINISH,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic search;
    logic shift;
    logic skip;
    logic finish;
    logic clear_out;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic shift_done;
    logic skip_done;
    logic need_insert;
    logic need_skip;
  } dp_status_t;

endpackage

// File: rtl/brrt_ctrl.sv
// ----------------------------------------------------------------------------
// Bus request/response tracker controller
// Sequences capture, ordered insert, skip walk and result hand-off.
// ----------------------------------------------------------------------------
module brrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  brrt_pkg::dp_status_t st,
  output brrt_pkg::dp_cmd_t    cmd
);
  import brrt_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (st.need_insert) begin
          cmd.search = 1'b1;
          if (st.search_done) state_nxt = ST_SHIFT;
        end else if (st.need_skip) begin
          state_nxt = ST_SKIP;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.shift_done) state_nxt = ST_FINISH;
      end
      ST_SKIP: begin
        cmd.skip = 1'b1;
        if (st.skip_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.clear_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/brrt_dp.sv
// ----------------------------------------------------------------------------
// Bus request/response tracker datapath
// Entry table, pointers, timing registers and result register.
// ----------------------------------------------------------------------------
module brrt_dp #(
  parameter int unsigned TABLE_ENTRIES = brrt_pkg::TableEntriesDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [111:0]         in_tdata,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  brrt_pkg::dp_cmd_t    cmd,
  output brrt_pkg::dp_status_t st,
  output logic [207:0]         out_tdata
);
  import brrt_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  logic [7:0]  dev_r [TABLE_ENTRIES];
  logic [15:0] com_r [TABLE_ENTRIES];
  logic        qry_r [TABLE_ENTRIES];
  logic [31:0] val_r [TABLE_ENTRIES];
  logic [47:0] stp_r [TABLE_ENTRIES];

  logic [CW-1:0] count_r, send_r, reply_r, pos_r, walk_r;
  logic [1:0]    phase_r;
  logic [47:0]   first_r, deadline_r, next_r, compl_r;
  logic [31:0]   expire_r;
  logic [15:0]   gap_r;

  logic [2:0]  op_r;
  logic [7:0]  bus_r;
  logic [15:0] code_r;
  logic        qf_r;
  logic [31:0] rval_r;
  logic [3:0]  idx_r;
  logic [47:0] now_r;
  logic        go_r;

  logic        o_sent_r, o_acc_r, o_exp_r, o_q_r;
  logic [7:0]  o_bus_r;
  logic [15:0] o_cmd_r;
  logic [31:0] o_val_r;
  logic [47:0] o_stamp_r;

  logic [IW-1:0] send_i, reply_i, pos_i, walk_i, walkm_i;
  logic          send_ok, reply_ok, reply_lt_send, idx_ok;
  logic [47:0]   first_eff;

  assign send_i  = send_r[IW-1:0];
  assign reply_i = reply_r[IW-1:0];
  assign pos_i   = pos_r[IW-1:0];
  assign walk_i  = walk_r[IW-1:0];
  assign walkm_i = IW'(walk_r - 1'b1);
  assign send_ok = send_r < count_r;
  assign reply_ok = reply_r < count_r;
  assign reply_lt_send = reply_r < send_r;
  assign idx_ok = (CW'(idx_r) < count_r) && (32'(idx_r) < TABLE_ENTRIES);

  assign st.need_insert = go_r && (op_r == OP_LOAD);
  assign st.search_done = (pos_r >= count_r) || (dev_r[pos_i] > bus_r);
  assign st.shift_done  = (walk_r == pos_r);
  assign st.need_skip   = go_r &&
                          (((op_r == OP_TRANSMIT) && (phase_r == PH_PENDING) &&
                            send_ok && reply_ok && (dev_r[send_i] == dev_r[reply_i])) ||
                           ((op_r == OP_RESPONSE) && reply_ok && reply_lt_send &&
                            (dev_r[reply_i] == bus_r) && (com_r[reply_i] == code_r)));
  assign st.skip_done   = (o_sent_r || o_acc_r) &&
                          !(reply_ok && reply_lt_send && !qry_r[reply_i]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expire_r <= '0;
      gap_r    <= QueryGapReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPIRE: expire_r <= cfg_wdata;
        CFG_GAP:    gap_r    <= cfg_wdata[15:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.finish && go_r && op_r == OP_CLEAR)) begin
      count_r <= '0; send_r <= '0; reply_r <= '0; phase_r <= PH_PENDING;
      first_r <= '0; deadline_r <= '0; next_r <= '0; compl_r <= '0;
      go_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        op_r   <= in_tdata[2:0];   bus_r <= in_tdata[10:3];
        code_r <= in_tdata[26:11]; qf_r  <= in_tdata[27];
        rval_r <= in_tdata[59:28]; idx_r <= in_tdata[63:60];
        now_r  <= in_tdata[111:64];
        go_r   <= 1'b1;
        pos_r  <= '0;
        walk_r <= count_r;
        {o_sent_r, o_acc_r, o_exp_r, o_q_r} <= '0;
        o_bus_r <= '0; o_cmd_r <= '0; o_val_r <= '0; o_stamp_r <= '0;
      end
      if (cmd.search && !st.search_done) pos_r <= pos_r + 1'b1;
      if (cmd.shift) begin
        if (walk_r != pos_r) begin
          dev_r[walk_i] <= dev_r[walkm_i]; com_r[walk_i] <= com_r[walkm_i];
          qry_r[walk_i] <= qry_r[walkm_i]; val_r[walk_i] <= val_r[walkm_i];
          stp_r[walk_i] <= stp_r[walkm_i];
          walk_r <= walk_r - 1'b1;
        end
      end
      if (cmd.search && st.search_done && (count_r >= CW'(TABLE_ENTRIES))) begin
        walk_r <= pos_r;
      end
      if (cmd.skip) begin
        if (walk_r == count_r && reply_r == reply_r && !o_acc_r && !o_sent_r) begin
          // First skip cycle: apply the transmit or response step.
          if (op_r == OP_TRANSMIT) begin
            o_sent_r <= 1'b1; o_bus_r <= dev_r[send_i];
            o_cmd_r <= com_r[send_i]; o_q_r <= qry_r[send_i];
            stp_r[send_i] <= now_r;
            send_r <= send_r + 1'b1;
            next_r <= qry_r[send_i] ? now_r + 48'(gap_r) : now_r;
          end else begin
            o_acc_r <= 1'b1;
            val_r[reply_i] <= rval_r; stp_r[reply_i] <= now_r;
            reply_r <= reply_r + 1'b1;
            deadline_r <= now_r + 48'(expire_r);
          end
        end else if (!st.skip_done) begin
          reply_r <= reply_r + 1'b1;
        end
      end
      if (cmd.finish && go_r) begin
        go_r <= 1'b0;
        case (op_r)
          OP_LOAD: begin
            if (count_r < CW'(TABLE_ENTRIES)) begin
              dev_r[pos_i] <= bus_r; com_r[pos_i] <= code_r; qry_r[pos_i] <= qf_r;
              val_r[pos_i] <= '0; stp_r[pos_i] <= '0;
              count_r <= count_r + 1'b1;
              o_acc_r <= 1'b1;
            end
          end
          OP_TRANSMIT: begin
            if (phase_r == PH_PENDING && first_r == '0) begin
              first_r    <= now_r;
              deadline_r <= now_r + 48'(expire_r);
            end
            if ((o_sent_r || o_acc_r) && phase_r == PH_PENDING &&
                !reply_ok && !send_ok) begin
              phase_r <= PH_DONE;
              compl_r <= now_r - first_eff;
            end
          end
          OP_RESPONSE: begin
            if (o_acc_r && phase_r == PH_PENDING && !reply_ok && !send_ok) begin
              phase_r <= PH_DONE;
              compl_r <= now_r - first_r;
            end
          end
          OP_CHECK: begin
            o_exp_r <= (phase_r == PH_EXPIRED) ||
                       ((deadline_r != '0) && (now_r > deadline_r));
          end
          OP_EXPIRE: begin
            phase_r <= PH_EXPIRED;
            o_exp_r <= 1'b1;
          end
          OP_READ: begin
            if (idx_ok) begin
              o_bus_r <= dev_r[IW'(idx_r)]; o_cmd_r <= com_r[IW'(idx_r)];
              o_q_r <= qry_r[IW'(idx_r)]; o_val_r <= val_r[IW'(idx_r)];
              o_stamp_r <= stp_r[IW'(idx_r)];
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign first_eff = (first_r == '0) ? now_r : first_r;

  assign out_tdata = {
    2'd0, compl_r, next_r, o_exp_r, phase_r, o_stamp_r, o_val_r, o_acc_r,
    o_q_r, o_cmd_r, o_bus_r, o_sent_r
  };

endmodule

// File: rtl/bus_request_response_tracker.sv
// Items are handled one at a time: a load searches and shifts the table, and a matched
//   transmit or response walks past the skipped entries before the result is offered.
// A new item is taken only after the previous result has been accepted.
// Reset (rst_n low, synchronous) empties the table, clears all tracking state
//   and returns the registers to expire interval 0 and query gap 1600.
// ----------------------------------------------------------------------------
// Bus request/response tracker
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module bus_request_response_tracker #(
  parameter int unsigned TABLE_ENTRIES = brrt_pkg::TableEntriesDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, bus_id, command_code, query_flag, response_value, entry_index, now_us
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sent, sent_bus_id, sent_command, sent_query, accepted, read_value,
  // read_stamp_us, status, expired_now, next_send_us, complete_us
  output logic [207:0] out_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import brrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  brrt_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .st, .cmd
  );

  brrt_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst_n, .in_tdata, .cfg_we, .cfg_index, .cfg_wdata, .cmd, .st, .out_tdata
  );

endmodule

// File: tb/tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bus request/response tracker checker
// Watches the configuration port and both streams, keeps its own copy of the
// entry table and transaction state, predicts one result per accepted item,
// and compares every accepted result field by field against the oldest one.
// ----------------------------------------------------------------------------
module tracker_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [207:0] out_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           waiting_count,
  output int           result_count
);
  import brrt_pkg::*;

  typedef struct packed {
    logic [47:0] now;
    logic [3:0]  idx;
    logic [31:0] rval;
    logic        query;
    logic [15:0] cmd;
    logic [7:0]  bus;
    logic [2:0]  op;
  } bus_item_t;

  typedef struct packed {
    logic [47:0] complete_us;
    logic [47:0] next_send_us;
    logic        expired_now;
    logic [1:0]  status;
    logic [47:0] read_stamp;
    logic [31:0] read_value;
    logic        accepted;
    logic        sent_query;
    logic [15:0] sent_command;
    logic [7:0]  sent_bus;
    logic        sent;
  } tracker_result_t;

  localparam int Entries = TableEntriesDefault;

  logic [7:0]  tbl_dev [Entries];
  logic [15:0] tbl_cmd [Entries];
  logic        tbl_qry [Entries];
  logic [31:0] tbl_val [Entries];
  logic [47:0] tbl_stamp [Entries];
  int          count, send_pos, reply_pos;
  logic [1:0]  txn_phase;
  logic [47:0] first_send, deadline_us, next_send, completion;
  logic [31:0] expire_interval;
  logic [15:0] query_gap;

  tracker_result_t expected_results[$];

  task automatic clear_tracking();
    count = 0;
    send_pos = 0;
    reply_pos = 0;
    txn_phase = PH_PENDING;
    first_send = '0;
    deadline_us = '0;
    next_send = '0;
    completion = '0;
  endtask

  task automatic skip_actions();
    while (reply_pos < count && reply_pos < send_pos && !tbl_qry[reply_pos])
      reply_pos++;
  endtask

  task automatic try_complete(input logic [47:0] now);
    if (txn_phase == PH_PENDING && reply_pos >= count && send_pos >= count) begin
      txn_phase = PH_DONE;
      completion = now - first_send;
    end
  endtask

  task automatic track_item(input bus_item_t it, output tracker_result_t r);
    int pos;
    int s;
    r = '0;
    case (it.op)
      OP_LOAD: begin
        if (count < Entries) begin
          pos = count;
          for (int i = 0; i < count; i++) begin
            if (tbl_dev[i] > it.bus) begin
              pos = i;
              break;
            end
          end
          for (int i = count; i > pos; i--) begin
            tbl_dev[i] = tbl_dev[i-1];
            tbl_cmd[i] = tbl_cmd[i-1];
            tbl_qry[i] = tbl_qry[i-1];
            tbl_val[i] = tbl_val[i-1];
            tbl_stamp[i] = tbl_stamp[i-1];
          end
          tbl_dev[pos] = it.bus;
          tbl_cmd[pos] = it.cmd;
          tbl_qry[pos] = it.query;
          tbl_val[pos] = '0;
          tbl_stamp[pos] = '0;
          count++;
          r.accepted = 1'b1;
        end
      end
      OP_TRANSMIT: begin
        if (txn_phase == PH_PENDING) begin
          if (first_send == '0) begin
            first_send = it.now;
            deadline_us = it.now + {16'b0, expire_interval};
          end
          if (send_pos < count && reply_pos < count &&
              tbl_dev[send_pos] == tbl_dev[reply_pos]) begin
            s = send_pos;
            r.sent = 1'b1;
            r.sent_bus = tbl_dev[s];
            r.sent_command = tbl_cmd[s];
            r.sent_query = tbl_qry[s];
            tbl_stamp[s] = it.now;
            send_pos++;
            skip_actions();
            try_complete(it.now);
            next_send = tbl_qry[s] ? it.now + {32'b0, query_gap} : it.now;
          end
        end
      end
      OP_RESPONSE: begin
        if (reply_pos < count && reply_pos < send_pos &&
            tbl_dev[reply_pos] == it.bus && tbl_cmd[reply_pos] == it.cmd) begin
          tbl_val[reply_pos] = it.rval;
          tbl_stamp[reply_pos] = it.now;
          reply_pos++;
          deadline_us = it.now + {16'b0, expire_interval};
          skip_actions();
          try_complete(it.now);
          r.accepted = 1'b1;
        end
      end
      OP_CHECK: begin
        if (txn_phase == PH_EXPIRED || (deadline_us != '0 && it.now > deadline_us))
          r.expired_now = 1'b1;
      end
      OP_EXPIRE: begin
        txn_phase = PH_EXPIRED;
        r.expired_now = 1'b1;
      end
      OP_READ: begin
        if (it.idx < count) begin
          r.sent_bus = tbl_dev[it.idx];
          r.sent_command = tbl_cmd[it.idx];
          r.sent_query = tbl_qry[it.idx];
          r.read_value = tbl_val[it.idx];
          r.read_stamp = tbl_stamp[it.idx];
        end
      end
      OP_CLEAR: clear_tracking();
      default: ;
    endcase
    r.status = txn_phase;
    r.next_send_us = next_send;
    r.complete_us = completion;
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch in result %0d, %s: got %0h, expected %0h",
             $realtime, result_count, field, got, want);
    fail_count++;
  endtask

  task automatic compare_result(input tracker_result_t got, input tracker_result_t want);
    if (got.sent !== want.sent) report_mismatch("sent", got.sent, want.sent);
    if (got.sent_bus !== want.sent_bus) report_mismatch("sent_bus_id", got.sent_bus, want.sent_bus);
    if (got.sent_command !== want.sent_command)
      report_mismatch("sent_command", got.sent_command, want.sent_command);
    if (got.sent_query !== want.sent_query)
      report_mismatch("sent_query", got.sent_query, want.sent_query);
    if (got.accepted !== want.accepted) report_mismatch("accepted", got.accepted, want.accepted);
    if (got.read_value !== want.read_value)
      report_mismatch("read_value", got.read_value, want.read_value);
    if (got.read_stamp !== want.read_stamp)
      report_mismatch("read_stamp_us", got.read_stamp, want.read_stamp);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.expired_now !== want.expired_now)
      report_mismatch("expired_now", got.expired_now, want.expired_now);
    if (got.next_send_us !== want.next_send_us)
      report_mismatch("next_send_us", got.next_send_us, want.next_send_us);
    if (got.complete_us !== want.complete_us)
      report_mismatch("complete_us", got.complete_us, want.complete_us);
  endtask

  assign waiting_count = expected_results.size();

  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst_n) begin
      clear_tracking();
      expire_interval = '0;
      query_gap = QueryGapReset;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result with no item outstanding", $realtime);
          fail_count++;
        end else begin
          compare_result(tracker_result_t'(out_tdata[205:0]), expected_results.pop_front());
        end
        result_count++;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_EXPIRE) expire_interval = cfg_wdata;
        else query_gap = cfg_wdata[15:0];
      end
      if (in_tvalid && in_tready) begin
        track_item(bus_item_t'(in_tdata), want);
        expected_results.push_back(want);
      end
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bus request/response tracker testbench
// Drives directed and random transactions (loads, transmits, responses,
// expiry checks, reads, clears) with random idling on both streams, changes
// the registers between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import brrt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [207:0] out_tdata;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  int           fail_count;
  int           waiting_count;
  int           result_count;

  int           items_sent;
  int           cycles = 0;
  logic [47:0]  now_us;
  logic         hold_request;
  logic         hold_done;
  logic [7:0]   dev_pool [4];
  logic [7:0]   pair_bus [$];
  logic [15:0]  pair_cmd [$];

  bus_request_response_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tracker_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .waiting_count(waiting_count),
    .result_count(result_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  initial begin
    int on_len;
    int off_len;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      on_len = $urandom_range(0, 99) < 20 ? $urandom_range(20, 60) : $urandom_range(1, 4);
      repeat (on_len) @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        off_len = pick_gap();
        if (off_len > 0) begin
          out_tready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  task automatic put_item(input logic [2:0] op, input logic [7:0] bus, input logic [15:0] cmd,
                          input logic query, input logic [31:0] rval, input logic [3:0] idx,
                          input logic [47:0] now);
    int gap;
    logic [111:0] packed_item;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    packed_item = {now, idx, rval, query, cmd, bus, op};
    in_tdata <= packed_item;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic put_random(input logic [2:0] op, input logic [47:0] now);
    put_item(op, 8'($urandom), 16'($urandom), 1'($urandom), $urandom, 4'($urandom), now);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_entry(input logic [7:0] bus, input logic [15:0] cmd, input logic query);
    put_item(OP_LOAD, bus, cmd, query, $urandom, 4'($urandom), now_us);
    pair_bus.push_back(bus);
    pair_cmd.push_back(cmd);
  endtask

  task automatic random_step();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) now_us = 48'({$urandom, $urandom});
    else now_us = now_us + 48'($urandom_range(1, 3000));
    if (r < 42) begin
      put_random(OP_TRANSMIT, now_us);
    end else if (r < 78) begin
      if (pair_bus.size() > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, pair_bus.size() - 1);
        put_item(OP_RESPONSE, pair_bus[k], pair_cmd[k], 1'($urandom), $urandom,
                 4'($urandom), now_us);
      end else begin
        put_random(OP_RESPONSE, now_us);
      end
    end else if (r < 86) begin
      put_random(OP_CHECK, now_us);
    end else if (r < 92) begin
      put_random(OP_READ, now_us);
    end else if (r < 94) begin
      put_random(OP_EXPIRE, now_us);
    end else if (r < 99) begin
      load_entry($urandom_range(0, 9) < 8 ? dev_pool[$urandom_range(0, 3)] : 8'($urandom),
                 16'($urandom), 1'($urandom));
    end else begin
      put_random(OP_UNUSED, now_us);
    end
  endtask

  task automatic new_transaction();
    int n;
    pair_bus.delete();
    pair_cmd.delete();
    for (int i = 0; i < 4; i++) dev_pool[i] = 8'($urandom);
    put_random(OP_CLEAR, now_us);
    n = $urandom_range(0, 19) == 0 ? 16 : $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      load_entry(dev_pool[$urandom_range(0, 1)], 16'($urandom_range(0, 3)), 1'($urandom));
  endtask

  initial begin
    logic [31:0] expire_values [6];
    logic [31:0] gap_values [6];
    int phase_no;
    int steps;
    expire_values = '{32'd0, 32'hFFFF_FFFF, 32'd500, 32'd3000, 32'd1, 32'd20000};
    gap_values = '{32'd0, 32'hFFFF, 32'd1600, 32'd1, 32'd77, 32'd40000};
    items_sent = 0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    now_us = 48'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty transmit, full table, refused load, reads, responses.
    put_item(OP_TRANSMIT, 8'h00, 16'h0000, 1'b0, 32'h0, 4'h0, 48'd0);
    put_item(OP_CHECK, 8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'hF, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 16; i++)
      put_item(OP_LOAD, 8'(i == 0 ? 255 : (i * 7) % 5), 16'(i == 1 ? 16'hFFFF : i),
               1'(i % 3 == 0), 32'h8000_0000, 4'hF, now_us);
    put_item(OP_LOAD, 8'h00, 16'h1234, 1'b1, 32'h0, 4'h0, now_us);
    put_item(OP_READ, 8'h0, 16'h0, 1'b0, 32'h0, 4'hF, now_us);
    put_item(OP_TRANSMIT, 8'h0, 16'h0, 1'b0, 32'h0, 4'h0, 48'd100);
    put_item(OP_TRANSMIT, 8'h0, 16'h0, 1'b0, 32'h0, 4'h0, 48'd200);
    put_item(OP_RESPONSE, 8'h0, 16'h0, 1'b1, 32'h7FFF_FFFF, 4'h0, 48'd300);
    put_item(OP_READ, 8'h0, 16'h0, 1'b0, 32'h0, 4'h0, now_us);
    put_item(OP_EXPIRE, 8'h0, 16'h0, 1'b0, 32'h0, 4'h0, 48'd400);
    put_item(OP_TRANSMIT, 8'h0, 16'h0, 1'b0, 32'h0, 4'h0, 48'd500);
    put_item(OP_CLEAR, 8'h0, 16'h0, 1'b0, 32'h0, 4'h0, 48'd0);
    put_item(OP_READ, 8'h0, 16'h0, 1'b0, 32'h0, 4'h3, 48'd0);
    put_item(OP_UNUSED, 8'h0, 16'h0, 1'b0, 32'h0, 4'h0, 48'd0);

    phase_no = 0;
    while (items_sent < 650) begin
      wait_idle();
      write_reg(CFG_EXPIRE, phase_no < 6 ? expire_values[phase_no] : $urandom_range(0, 5000));
      write_reg(CFG_GAP, phase_no < 6 ? gap_values[phase_no] : $urandom_range(0, 65535));
      phase_no++;
      steps = 0;
      while (steps < 100 && items_sent < 650) begin
        new_transaction();
        for (int i = 0; i < $urandom_range(8, 30); i++) begin
          random_step();
          steps++;
          if (items_sent >= 300 && !hold_done) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
          end
        end
        if (phase_no == 3 && steps > 50) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (waiting_count != 0) @(posedge clk);
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d items over %0d register settings; %0d results checked.",
             items_sent, phase_no, result_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/brrt_pkg.sv
rtl/brrt_ctrl.sv
rtl/brrt_dp.sv
rtl/bus_request_response_tracker.sv
tb/tracker_checker.sv
tb/testbench.sv
